FILE: hw/rtl/gsbo_pkg.sv
// Shared types and constants of the gas sensor baseline settle and onset block.
// Used by gsbo_onset_line and gas_sensor_baseline_settle_and_onset; no dependencies.
package gsbo_pkg;

   // Samples per averaging window (a power of two; the mean is an arithmetic shift)
   localparam int WINDOW      = 16;
   localparam int WIN_LOG     = $clog2(WINDOW);
   // Depth of the onset delay line
   localparam int ONSET_DEPTH = 100;
   localparam int IDX_W       = $clog2(ONSET_DEPTH);
   localparam int FILL_W      = $clog2(ONSET_DEPTH + 1);

   // Field widths
   localparam int OP_W        = 2;
   localparam int SAMPLE_W    = 16;
   localparam int STATUS_W    = 3;
   localparam int SLOPE_W     = 8;
   localparam int RUNS_W      = 3;
   localparam int THR_W       = 15;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 15;
   localparam int WSUM_W      = SAMPLE_W + WIN_LOG;

   // Saturation of the flat-run counter
   localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_LIMIT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAT_RUNS_NEEDED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_THRESHOLD   = 2'd2;

   // Register reset values
   localparam logic [SLOPE_W-1:0] SLOPE_RESET = 8'd8;
   localparam logic [RUNS_W-1:0]  RUNS_RESET  = 3'd5;
   localparam logic [THR_W-1:0]   THR_RESET   = 15'd200;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE = 2'd0,
      OP_START  = 2'd1,
      OP_ABORT  = 2'd2,
      OP_HOLD   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_IDLE   = 3'd0,
      ST_SETTLE = 3'd1,
      ST_DETECT = 3'd2,
      ST_ONSET  = 3'd3,
      ST_ABORT  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SETTLE = 2'd1,
      PH_DETECT = 2'd2
   } phase_type;

   // Control from the sequencer to the delay line
   typedef struct packed {
      logic clear;
      logic push;
   } line_ctl_type;

endpackage

FILE: hw/rtl/gsbo_onset_line.sv
// Onset delay line: a ring memory with a head pointer and a fill count.
// Depends on gsbo_pkg.
module gsbo_onset_line (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gsbo_pkg::line_ctl_type                 ctl,
   input  logic signed [gsbo_pkg::SAMPLE_W-1:0]   push_sample,
   output logic signed [gsbo_pkg::SAMPLE_W-1:0]   oldest,
   output logic signed [gsbo_pkg::SAMPLE_W-1:0]   newest
);
   import gsbo_pkg::*;

   logic signed [SAMPLE_W-1:0] mem [ONSET_DEPTH];
   logic signed [SAMPLE_W-1:0] rdata_ff;
   logic [IDX_W-1:0]           head_ff, head_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [IDX_W-1:0]           rd_addr, wr_addr;
   logic                       full;
   logic [IDX_W-1:0]           head_next;

   assign full      = (fill_ff == FILL_W'(ONSET_DEPTH));
   assign head_next = (head_ff == IDX_W'(ONSET_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // Oldest entry: slot 0 while filling, the one after the head once full
   assign rd_addr = full ? head_next : '0;
   // Fill upward from slot 0, then overwrite the oldest entry
   assign wr_addr = full ? head_ff : fill_ff[IDX_W-1:0];

   // Logical view after this beat's write; unwritten slots read as zero
   assign oldest = (fill_ff == '0) ? push_sample : rdata_ff;
   assign newest = (fill_ff >= FILL_W'(ONSET_DEPTH - 1)) ? push_sample : '0;

   // Advance pointers
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (ctl.clear) begin
         head_in = '0;
         fill_in = '0;
      end else if (ctl.push) begin
         if (full) begin
            head_in = head_next;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   // Ring memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.push && !ctl.clear) begin
         mem[wr_addr] <= push_sample;
      end
      rdata_ff <= mem[rd_addr];
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(ONSET_DEPTH))
      else $error("delay line fill count past depth");

   a_head_only_full: assert property (@(posedge clock) disable iff (reset)
      head_ff != '0 |-> full)
      else $error("head pointer moved before the line filled");

   a_clear_resets: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> fill_ff == '0 && head_ff == '0)
      else $error("delay line clear did not reset pointers");

endmodule

FILE: hw/rtl/gas_sensor_baseline_settle_and_onset.sv
// Top level of the gas sensor baseline settle and onset detector.
// Depends on gsbo_pkg and gsbo_onset_line.

// Each request beat has a read step, which reads the oldest entry of the
// onset delay line from its ring memory, and an evaluate step, which
// evaluates the beat, writes the new sample back and registers the response.
// A new request is taken in the cycle its predecessor writes back; the
// response register lets the next request enter while a finished response
// waits. Settling sums live in registers; the delay line is the only memory
// and, as a fill count makes unwritten slots read as zero, needs no clearing
// pass after reset or on entering detection. The user must write the
// configuration registers through csr_write_en/csr_index/csr_wdata only
// while the block is idle; the block itself does not enforce this.
module gas_sensor_baseline_settle_and_onset (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_write_en,
   input  logic [gsbo_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [gsbo_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [gsbo_pkg::OP_W-1:0]              req_operation,
   input  logic signed [gsbo_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                   req_check_tick,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [gsbo_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [gsbo_pkg::SAMPLE_W-1:0]   rsp_baseline_value,
   output logic                                   rsp_settled_now
);
   import gsbo_pkg::*;

   localparam int CMP_W  = WSUM_W + 2;
   localparam int RISE_W = SAMPLE_W + 2;

   // Configuration registers
   logic [SLOPE_W-1:0] slope_limit_ff;
   logic [RUNS_W-1:0]  flat_runs_needed_ff;
   logic [THR_W-1:0]   rise_threshold_ff;

   // Beat in flight
   logic                       busy_ff, exec_ff;
   op_type                     op_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       tick_ff;
   logic                       req_fire, ex_fire;

   // Block state
   phase_type                  phase_ff, phase_in;
   logic signed [WSUM_W-1:0]   window_sum_ff, window_sum_in;
   logic signed [WSUM_W-1:0]   first_sum_ff, first_sum_in;
   logic [WIN_LOG-1:0]         win_cnt_ff, win_cnt_in;
   logic                       second_ff, second_in;
   logic [RUNS_W-1:0]          flat_runs_ff, flat_runs_in;
   logic signed [SAMPLE_W-1:0] baseline_ff, baseline_in;

   // Response register
   logic                       rsp_valid_ff;
   status_type                 rsp_status_ff, status_in;
   logic                       rsp_settled_ff, settled_in;

   // Datapath
   logic signed [WSUM_W-1:0]   sum_next, sum_adj, mean_full;
   logic signed [WSUM_W:0]     diff;
   logic [WSUM_W:0]            mag;
   logic [CMP_W-1:0]           twice_mag, limit_scaled;
   logic                       win_last, flat;
   logic [RUNS_W-1:0]          runs_inc;
   logic signed [SAMPLE_W-1:0] oldest, newest;
   logic signed [RISE_W-1:0]   rise;
   line_ctl_type               line_ctl;

   // Handshake
   assign ex_fire   = busy_ff && exec_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy_ff || ex_fire;
   assign req_fire  = req_valid && req_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_baseline_value = baseline_ff;
   assign rsp_settled_now    = rsp_settled_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slope_limit_ff      <= SLOPE_RESET;
         flat_runs_needed_ff <= RUNS_RESET;
         rise_threshold_ff   <= THR_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SLOPE_LIMIT:      slope_limit_ff      <= csr_wdata[SLOPE_W-1:0];
            CSR_FLAT_RUNS_NEEDED: flat_runs_needed_ff <= csr_wdata[RUNS_W-1:0];
            CSR_RISE_THRESHOLD:   rise_threshold_ff   <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // Settling arithmetic: window sum, slope test and truncated mean
   assign sum_next     = window_sum_ff + WSUM_W'(sample_ff);
   assign win_last     = (win_cnt_ff == WIN_LOG'(WINDOW - 1));
   assign diff         = (WSUM_W+1)'(first_sum_ff) - (WSUM_W+1)'(sum_next);
   assign mag          = diff[WSUM_W] ? (WSUM_W+1)'(-diff) : (WSUM_W+1)'(diff);
   assign twice_mag    = {1'b0, mag} << 1;
   assign limit_scaled = CMP_W'(slope_limit_ff) * CMP_W'(WINDOW);
   assign flat         = (twice_mag < limit_scaled);
   assign runs_inc     = (flat_runs_ff == RUNS_MAX) ? RUNS_MAX : flat_runs_ff + 1'b1;
   assign sum_adj      = sum_next + (sum_next[WSUM_W-1] ? WSUM_W'(WINDOW - 1) : '0);
   assign mean_full    = sum_adj >>> WIN_LOG;

   // Onset test
   assign rise = RISE_W'(newest) - RISE_W'(oldest);

   // Evaluate the beat in its evaluate cycle
   always_comb begin
      phase_in      = phase_ff;
      window_sum_in = window_sum_ff;
      first_sum_in  = first_sum_ff;
      win_cnt_in    = win_cnt_ff;
      second_in     = second_ff;
      flat_runs_in  = flat_runs_ff;
      baseline_in   = baseline_ff;
      status_in     = rsp_status_ff;
      settled_in    = 1'b0;
      line_ctl      = '0;
      if (ex_fire) begin
         unique case (op_ff)
            OP_START: begin
               window_sum_in = '0;
               first_sum_in  = '0;
               win_cnt_in    = '0;
               second_in     = 1'b0;
               flat_runs_in  = '0;
               phase_in      = PH_SETTLE;
               status_in     = ST_SETTLE;
            end
            OP_ABORT: begin
               phase_in  = PH_IDLE;
               status_in = ST_ABORT;
            end
            OP_HOLD: begin
               unique case (phase_ff)
                  PH_SETTLE: status_in = ST_SETTLE;
                  PH_DETECT: status_in = ST_DETECT;
                  default:   status_in = ST_IDLE;
               endcase
            end
            OP_SAMPLE: begin
               unique case (phase_ff)
                  PH_SETTLE: begin
                     status_in     = ST_SETTLE;
                     window_sum_in = sum_next;
                     win_cnt_in    = win_cnt_ff + 1'b1;
                     if (win_last) begin
                        window_sum_in = '0;
                        win_cnt_in    = '0;
                        if (!second_ff) begin
                           first_sum_in = sum_next;
                           second_in    = 1'b1;
                        end else begin
                           second_in = 1'b0;
                           if (flat) begin
                              flat_runs_in = runs_inc;
                              if (runs_inc >= flat_runs_needed_ff) begin
                                 baseline_in    = mean_full[SAMPLE_W-1:0];
                                 phase_in       = PH_DETECT;
                                 line_ctl.clear = 1'b1;
                                 settled_in     = 1'b1;
                                 status_in      = ST_DETECT;
                              end
                           end else begin
                              flat_runs_in = '0;
                           end
                        end
                     end
                  end
                  PH_DETECT: begin
                     line_ctl.push = 1'b1;
                     status_in     = ST_DETECT;
                     if (tick_ff) begin
                        baseline_in = oldest;
                        if (rise > $signed(RISE_W'(rise_threshold_ff))) begin
                           phase_in  = PH_IDLE;
                           status_in = ST_ONSET;
                        end
                     end
                  end
                  default: status_in = ST_IDLE;
               endcase
            end
            default: ;
         endcase
      end
   end

   // Hold the beat in flight: read cycle, then evaluate cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         exec_ff <= 1'b0;
      end else if (req_fire) begin
         busy_ff <= 1'b1;
         exec_ff <= 1'b0;
      end else if (busy_ff && !exec_ff) begin
         exec_ff <= 1'b1;
      end else if (ex_fire) begin
         busy_ff <= 1'b0;
         exec_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= op_type'(req_operation);
         sample_ff <= req_sample;
         tick_ff   <= req_check_tick;
      end
   end

   // Update block state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         window_sum_ff <= '0;
         first_sum_ff  <= '0;
         win_cnt_ff    <= '0;
         second_ff     <= 1'b0;
         flat_runs_ff  <= '0;
         baseline_ff   <= '0;
      end else begin
         phase_ff      <= phase_in;
         window_sum_ff <= window_sum_in;
         first_sum_ff  <= first_sum_in;
         win_cnt_ff    <= win_cnt_in;
         second_ff     <= second_in;
         flat_runs_ff  <= flat_runs_in;
         baseline_ff   <= baseline_in;
      end
   end

   // Drive the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         rsp_status_ff  <= ST_IDLE;
         rsp_settled_ff <= 1'b0;
      end else if (ex_fire) begin
         rsp_valid_ff   <= 1'b1;
         rsp_status_ff  <= status_in;
         rsp_settled_ff <= settled_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   gsbo_onset_line u_line (
      .clock       (clock),
      .reset       (reset),
      .ctl         (line_ctl),
      .push_sample (sample_ff),
      .oldest      (oldest),
      .newest      (newest)
   );

   a_read_then_exec: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !exec_ff |=> busy_ff && exec_ff)
      else $error("beat skipped its evaluate cycle");

   a_settled_detect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_settled_ff |-> rsp_status_ff == ST_DETECT)
      else $error("settled beat not reported as detecting");

   a_push_in_detect: assert property (@(posedge clock) disable iff (reset)
      line_ctl.push |-> phase_ff == PH_DETECT && ex_fire)
      else $error("delay line written outside detection");

   a_no_push_clear: assert property (@(posedge clock) disable iff (reset)
      !(line_ctl.push && line_ctl.clear))
      else $error("delay line push and clear together");

endmodule
